>>> rtl/core/sphere_edge_midpoint_normalizer_top_defines.svh
// Assertion macros for the sphere edge midpoint normaliser checker.
`ifndef SPHERE_EDGE_MIDPOINT_NORMALIZER_TOP_DEFINES_SVH
`define SPHERE_EDGE_MIDPOINT_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sem_pkg.sv
// Package: types, widths and codes of the sphere edge midpoint normaliser.
package sem_pkg;

   localparam int COORD_FRAC_BITS = 14;
   localparam int COORD_W         = 16;
   localparam int EDGE_W          = 2;
   localparam int N_EDGES         = 3;
   localparam int ITEM_CYCLES     = N_EDGES;
   localparam int COOL_W          = $clog2(ITEM_CYCLES);

   // |midpoint component| <= 2^15, so it fits COORD_W unsigned bits
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int SQ_STAGES  = ROOT_W / 2;
   localparam int NUM_W      = MAG_W + COORD_FRAC_BITS;
   localparam int QUO_W      = COORD_FRAC_BITS + 1;
   localparam int DIV_STAGES = (QUO_W + 1) / 2;
   localparam int EXT_W      = ((QUO_W > COORD_W) ? QUO_W : COORD_W) + 1;
   localparam int DIV_LAT    = DIV_STAGES + 2;
   localparam int LANE_LAT   = 3 + SQ_STAGES + DIV_LAT;

   typedef enum logic [EDGE_W-1:0] {
      EDGE_AB = 2'd0,
      EDGE_BC = 2'd1,
      EDGE_CA = 2'd2
   } edge_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
      logic [EDGE_W-1:0]         edge_id;
      logic                      last_of_run;
      logic                      degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
      logic                      degenerate;
   } lane_res_type;

endpackage

>>> rtl/core/sem_div.sv
// Pipelined restoring divider: (mag << frac) / len, saturated and signed.
module sem_div (
   input  logic                              clock,
   input  logic [sem_pkg::MAG_W-1:0]         mag,
   input  logic                              neg,
   input  logic [sem_pkg::ROOT_W-1:0]        len,
   output logic [sem_pkg::COORD_W-1:0]       coord
);

   localparam int F  = sem_pkg::COORD_FRAC_BITS;
   localparam int NW = sem_pkg::NUM_W;
   localparam int QW = sem_pkg::QUO_W;
   localparam int NS = sem_pkg::DIV_STAGES;
   localparam int XW = sem_pkg::EXT_W;

   logic [NW-1:0]                 rem_ff [0:NS];
   logic [QW-1:0]                 quo_ff [0:NS];
   logic [sem_pkg::ROOT_W-1:0]    den_ff [0:NS];
   logic                          neg_ff [0:NS];
   logic                          sat_ff [0:NS];
   logic [sem_pkg::COORD_W-1:0]   coord_ff;

   logic [NW-1:0]                 num_in;
   logic [NW:0]                   lim_in;
   logic                          sat_in;
   logic [QW-1:0]                 qf_in;
   logic [XW-1:0]                 ext_in;
   logic [sem_pkg::COORD_W-1:0]   coord_in;

   // saturate when quotient would exceed 1.0: num >= (2^F + 1) * len
   always_comb begin
      num_in = NW'(mag) << F;
      lim_in = ((NW + 1)'(len) << F) + (NW + 1)'(len);
      sat_in = {1'b0, num_in} >= lim_in;
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_in;
      quo_ff[0] <= '0;
      den_ff[0] <= len;
      neg_ff[0] <= neg;
      sat_ff[0] <= sat_in;
   end

   for (genvar s = 0; s < NS; s++) begin : g_step
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      // two quotient bits per stage, one in the last
      always_comb begin
         int            b;
         logic [NW-1:0] d;
         rem_in = rem_ff[s];
         quo_in = quo_ff[s];
         for (int k = 0; k < 2; k++) begin
            b = QW - 1 - 2 * s - k;
            if (b >= 0) begin
               d = NW'(den_ff[s]) << b;
               if (rem_in >= d) begin
                  rem_in    = rem_in - d;
                  quo_in[b] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= rem_in;
         quo_ff[s+1] <= quo_in;
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         sat_ff[s+1] <= sat_ff[s];
      end
   end

   always_comb begin
      qf_in    = sat_ff[NS] ? (QW'(1) << F) : quo_ff[NS];
      ext_in   = neg_ff[NS] ? (XW'(0) - XW'(qf_in)) : XW'(qf_in);
      coord_in = ext_in[sem_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule

>>> rtl/core/sem_lane.sv
// One edge lane: midpoint, squared length, pipelined square root, three dividers.
module sem_lane (
   input  logic                   clock,
   input  sem_pkg::vec_type       p,
   input  sem_pkg::vec_type       q,
   output sem_pkg::lane_res_type  res
);

   localparam int MW = sem_pkg::MAG_W;
   localparam int SW = sem_pkg::SQ_W;
   localparam int RW = sem_pkg::ROOT_W;
   localparam int NS = sem_pkg::SQ_STAGES;

   typedef struct packed {
      logic [2:0][MW-1:0] mag;
      logic [2:0]         neg;
      logic               deg;
   } carry_type;

   carry_type      car_a_ff, car_b_ff;
   carry_type      car_a_in;
   carry_type      car_s_in;
   logic [SW-1:0]  sqm_ff [0:2];
   carry_type      car_ff  [0:NS];
   logic [SW-1:0]  srem_ff [0:NS];
   logic [RW-1:0]  sres_ff [0:NS];
   logic           deg_ff  [0:sem_pkg::DIV_LAT-1];
   logic [SW-1:0]  sum_in;
   logic [sem_pkg::COORD_W-1:0] crd [0:2];

   // halve by arithmetic shift: bits [16:1] of the 17-bit sum
   always_comb begin
      logic signed [sem_pkg::COORD_W:0]   s [0:2];
      logic signed [sem_pkg::COORD_W-1:0] h [0:2];
      s[0] = {p.x[sem_pkg::COORD_W-1], p.x} + {q.x[sem_pkg::COORD_W-1], q.x};
      s[1] = {p.y[sem_pkg::COORD_W-1], p.y} + {q.y[sem_pkg::COORD_W-1], q.y};
      s[2] = {p.z[sem_pkg::COORD_W-1], p.z} + {q.z[sem_pkg::COORD_W-1], q.z};
      car_a_in = '0;
      for (int i = 0; i < 3; i++) begin
         h[i]            = s[i][sem_pkg::COORD_W:1];
         car_a_in.neg[i] = h[i][sem_pkg::COORD_W-1];
         car_a_in.mag[i] = car_a_in.neg[i] ? MW'(-h[i]) : MW'(h[i]);
      end
   end

   always_ff @(posedge clock) begin
      car_a_ff <= car_a_in;
      car_b_ff <= car_a_ff;
      for (int i = 0; i < 3; i++) begin
         sqm_ff[i] <= SW'(car_a_ff.mag[i]) * SW'(car_a_ff.mag[i]);
      end
   end

   assign sum_in = sqm_ff[0] + sqm_ff[1] + sqm_ff[2];

   always_comb begin
      car_s_in     = car_b_ff;
      car_s_in.deg = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      srem_ff[0] <= sum_in;
      sres_ff[0] <= '0;
      car_ff[0]  <= car_s_in;
   end

   // bit-serial square root, two root bits per stage
   for (genvar s = 0; s < NS; s++) begin : g_sqrt
      logic [SW-1:0] rem_in;
      logic [RW-1:0] res_in;

      always_comb begin
         int          b;
         logic [SW:0] t;
         rem_in = srem_ff[s];
         res_in = sres_ff[s];
         for (int k = 0; k < 2; k++) begin
            b = RW - 1 - 2 * s - k;
            t = ((SW + 1)'(res_in) << (b + 1)) | ((SW + 1)'(1) << (2 * b));
            if ({1'b0, rem_in} >= t) begin
               rem_in    = rem_in - t[SW-1:0];
               res_in[b] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         srem_ff[s+1] <= rem_in;
         sres_ff[s+1] <= res_in;
         car_ff[s+1]  <= car_ff[s];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      sem_div u_div (
         .clock (clock),
         .mag   (car_ff[NS].mag[i]),
         .neg   (car_ff[NS].neg[i]),
         .len   (sres_ff[NS]),
         .coord (crd[i])
      );
   end

   always_ff @(posedge clock) begin
      deg_ff[0] <= car_ff[NS].deg;
      for (int i = 1; i < sem_pkg::DIV_LAT; i++) begin
         deg_ff[i] <= deg_ff[i-1];
      end
   end

   always_comb begin
      res.degenerate = deg_ff[sem_pkg::DIV_LAT-1];
      res.mid_x      = res.degenerate ? '0 : crd[0];
      res.mid_y      = res.degenerate ? '0 : crd[1];
      res.mid_z      = res.degenerate ? '0 : crd[2];
   end

endmodule

>>> rtl/core/sem_merge.sv
// Merging stage: serialises the three lane results of an item, ab then bc then ca.
module sem_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  done,
   input  sem_pkg::lane_res_type res [0:sem_pkg::N_EDGES-1],
   output logic                  rsp_strobe,
   output sem_pkg::rsp_type      rsp_payload
);

   sem_pkg::lane_res_type hold_ff [0:sem_pkg::N_EDGES-1];
   sem_pkg::edge_type     phase_ff;
   logic                  act_ff;
   logic                  strobe_ff;
   sem_pkg::rsp_type      rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         phase_ff  <= sem_pkg::EDGE_AB;
      end else if (done) begin
         act_ff    <= 1'b1;
         strobe_ff <= 1'b1;
         phase_ff  <= sem_pkg::EDGE_BC;
      end else if (act_ff) begin
         strobe_ff <= 1'b1;
         unique case (phase_ff)
            sem_pkg::EDGE_BC: begin
               phase_ff <= sem_pkg::EDGE_CA;
            end
            default: begin
               act_ff   <= 1'b0;
               phase_ff <= sem_pkg::EDGE_AB;
            end
         endcase
      end else begin
         strobe_ff <= 1'b0;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (done) begin
         hold_ff                <= res;
         rsp_ff.mid_x           <= res[0].mid_x;
         rsp_ff.mid_y           <= res[0].mid_y;
         rsp_ff.mid_z           <= res[0].mid_z;
         rsp_ff.degenerate      <= res[0].degenerate;
         rsp_ff.edge_id         <= sem_pkg::EDGE_AB;
         rsp_ff.last_of_run     <= 1'b0;
      end else begin
         rsp_ff.mid_x           <= hold_ff[phase_ff].mid_x;
         rsp_ff.mid_y           <= hold_ff[phase_ff].mid_y;
         rsp_ff.mid_z           <= hold_ff[phase_ff].mid_z;
         rsp_ff.degenerate      <= hold_ff[phase_ff].degenerate;
         rsp_ff.edge_id         <= phase_ff;
         rsp_ff.last_of_run     <= (phase_ff == sem_pkg::EDGE_CA);
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/sphere_edge_midpoint_normalizer_top.sv
// Top level of the sphere edge midpoint normaliser.
//
// Takes one triangle (corners a, b, c, signed Q1.14) when start is high and
// busy is low, and gives three results on consecutive cycles, edges ab, bc,
// ca, each marked by rsp_strobe for one cycle; last_of_run flags the ca
// result. Each edge result is the halved corner sum projected back onto the
// unit sphere: truncating integer square root of the squared length, divide
// toward zero, saturate to +/-1.0; a zero-length midpoint gives zero
// coordinates with degenerate set. The single result port carries three
// results per item, so busy rises after each accept and holds off the next
// triangle until the port has room for its results; earlier items may still
// be in the pipeline when a new one enters. Each item passes the midpoint,
// square and sum registers, an 8-stage square root, a 10-stage divider and
// the merge register. The receiver cannot stall and the block never drops a
// result, since busy spaces the items so that the merge stage has sent all
// three results of one before the next arrives. Three lanes, one per edge,
// run in parallel; a merge stage serialises their results.
module sphere_edge_midpoint_normalizer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sem_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output sem_pkg::rsp_type  rsp_payload
);

   logic [sem_pkg::COOL_W-1:0]   cool_ff, cool_in;
   logic [sem_pkg::LANE_LAT-1:0] vld_ff, vld_in;
   logic                         accept;
   sem_pkg::vec_type             va, vb, vc;
   sem_pkg::lane_res_type        lres [0:sem_pkg::N_EDGES-1];

   assign accept = start & ~busy;
   assign busy   = (cool_ff != '0);

   // cooldown: busy holds off a new item after each accept until the counter runs out
   always_comb begin
      if (accept) begin
         cool_in = sem_pkg::COOL_W'(sem_pkg::ITEM_CYCLES - 1);
      end else if (cool_ff != '0) begin
         cool_in = cool_ff - 1'b1;
      end else begin
         cool_in = '0;
      end
      vld_in = {vld_ff[sem_pkg::LANE_LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cool_ff <= '0;
         vld_ff  <= '0;
      end else begin
         cool_ff <= cool_in;
         vld_ff  <= vld_in;
      end
   end

   assign va = '{x: req_payload.a_x, y: req_payload.a_y, z: req_payload.a_z};
   assign vb = '{x: req_payload.b_x, y: req_payload.b_y, z: req_payload.b_z};
   assign vc = '{x: req_payload.c_x, y: req_payload.c_y, z: req_payload.c_z};

   // lanes run free; vld_ff tracks which cycles carry an accepted item
   sem_lane u_lane_ab (.clock(clock), .p(va), .q(vb), .res(lres[0]));
   sem_lane u_lane_bc (.clock(clock), .p(vb), .q(vc), .res(lres[1]));
   sem_lane u_lane_ca (.clock(clock), .p(vc), .q(va), .res(lres[2]));

   sem_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .done        (vld_ff[sem_pkg::LANE_LAT-1]),
      .res         (lres),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/sem_checker.sv
// Port-level checker for the sphere edge midpoint normaliser, with its bind.
`include "sphere_edge_midpoint_normalizer_top_defines.svh"

module sem_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input sem_pkg::rsp_type  rsp_payload
);

   logic accept_seen;
   logic ab_seen;
   logic bc_seen;
   logic last_ok;
   logic zero_mid;

   assign accept_seen = start && !busy;
   assign ab_seen     = rsp_strobe && (rsp_payload.edge_id == sem_pkg::EDGE_AB);
   assign bc_seen     = rsp_strobe && (rsp_payload.edge_id == sem_pkg::EDGE_BC);
   assign last_ok     = rsp_payload.last_of_run == (rsp_payload.edge_id == sem_pkg::EDGE_CA);
   assign zero_mid    = (rsp_payload.mid_x == '0) && (rsp_payload.mid_y == '0)
                        && (rsp_payload.mid_z == '0);

   `SEM_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept_seen, busy, "busy not raised")
   `SEM_ASSERT_NEXT(a_ab_then_bc, clock, reset, ab_seen, bc_seen, "bc does not follow ab")
   `SEM_ASSERT_NOW(a_last_on_ca, clock, reset, rsp_strobe, last_ok, "last_of_run not on ca")
   `SEM_ASSERT_NOW(a_degenerate_zero, clock, reset, rsp_strobe && rsp_payload.degenerate, zero_mid, "degenerate not zero")

endmodule

bind sphere_edge_midpoint_normalizer_top sem_checker u_sem_checker (.*);

>>> test/sphere_edge_midpoint_normalizer_checker.sv
// Checker: predicts normalised edge midpoints and compares them with the result items.
`timescale 1ns / 1ps
module sphere_edge_midpoint_normalizer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  sem_pkg::req_type  req_payload,
   input  logic              rsp_strobe,
   input  sem_pkg::rsp_type  rsp_payload,
   output int                fail_count,
   output int                pending
);
   import sem_pkg::*;

   rsp_type midpoint_queue[$];

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] project(longint m, longint unsigned len);
      longint unsigned q, one;
      one = 64'd1 << COORD_FRAC_BITS;
      q = ((m < 0 ? -m : m) << COORD_FRAC_BITS) / len;
      if (q > one) q = one;
      if (m < 0) q = -q;
      return q[COORD_W-1:0];
   endfunction

   function automatic rsp_type edge_midpoint(vec_type p, vec_type q, edge_type id);
      rsp_type r;
      longint m[3];
      longint unsigned sq, len;
      m[0] = (longint'(p.x) + longint'(q.x)) >>> 1;
      m[1] = (longint'(p.y) + longint'(q.y)) >>> 1;
      m[2] = (longint'(p.z) + longint'(q.z)) >>> 1;
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = '0;
      r.edge_id = id;
      r.last_of_run = (id == EDGE_CA);
      if (sq == 0) begin
         r.degenerate = 1'b1;
      end else begin
         len = root_floor(sq);
         r.mid_x = project(m[0], len);
         r.mid_y = project(m[1], len);
         r.mid_z = project(m[2], len);
      end
      return r;
   endfunction

   assign pending = midpoint_queue.size();

   always @(posedge clock) begin
      vec_type a, b, c;
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy) begin
            a = '{req_payload.a_x, req_payload.a_y, req_payload.a_z};
            b = '{req_payload.b_x, req_payload.b_y, req_payload.b_z};
            c = '{req_payload.c_x, req_payload.c_y, req_payload.c_z};
            midpoint_queue.push_back(edge_midpoint(a, b, EDGE_AB));
            midpoint_queue.push_back(edge_midpoint(b, c, EDGE_BC));
            midpoint_queue.push_back(edge_midpoint(c, a, EDGE_CA));
         end
         if (rsp_strobe) begin
            if (midpoint_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item %h", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = midpoint_queue.pop_front();
               if (rsp_payload !== want) begin
                  if (fail_count < 10)
                     $display("edge %0d: want x %0d y %0d z %0d deg %b last %b,",
                        want.edge_id, want.mid_x, want.mid_y, want.mid_z,
                        want.degenerate, want.last_of_run,
                        " got edge %0d x %0d y %0d z %0d deg %b last %b",
                        rsp_payload.edge_id, rsp_payload.mid_x, rsp_payload.mid_y,
                        rsp_payload.mid_z, rsp_payload.degenerate,
                        rsp_payload.last_of_run);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> test/sphere_edge_midpoint_normalizer_top_tb.sv
// Testbench top: triangle stimulus, clock, reset and the verdict.
`timescale 1ns / 1ps
module sphere_edge_midpoint_normalizer_top_tb;
   import sem_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending;

   always #6 clock = ~clock;

   sphere_edge_midpoint_normalizer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   sphere_edge_midpoint_normalizer_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending(pending)
   );

   // A coordinate: mostly on-range values, some exact extremes, some raw patterns.
   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         1:       return COORD_W'($urandom());
         2:       return COORD_W'($urandom_range(0, 2) - 1);
         default: return COORD_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // Offers one item and holds start until it is taken; start stays high when
   // another item follows straight after, so it is never dropped and raised in one step.
   task automatic offer(req_type item, bit idle_ok);
      req_payload <= item;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic req_type tri_of(int a, int b, int c);
      req_type            t;
      logic [COORD_W-1:0] ta, tb, tc;
      ta = COORD_W'(a);
      tb = COORD_W'(b);
      tc = COORD_W'(c);
      t = '{ta, ta, ta, tb, tb, tb, tc, tc, tc};
      return t;
   endfunction

   initial begin
      req_type t;
      int      k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: octahedron faces, extremes, opposite corners (zero-length
      // midpoints), raw 16-bit extremes and odd sums that round downward.
      offer('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 0);
      offer('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 0);
      offer('{16384, 0, 0, -16384, 0, 0, 0, 16384, 0}, 0);
      offer(tri_of(16384, -16384, 16384), 0);
      offer(tri_of(0, 0, 0), 0);
      offer(tri_of(32767, -32768, 32767), 0);
      offer(tri_of(-32768, -32768, 32767), 0);
      offer(tri_of(-1, 0, 1), 0);
      offer(tri_of(-1, -1, 1), 0);
      offer('{1, 0, 0, 0, 0, 0, -1, 0, 0}, 0);
      offer('{16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 0,
              16'h1234, 16'hFEDC, 16'h4000}, 0);
      offer(tri_of(16384, 16384, -16384), 0);
      start <= 1'b0;

      // Sender pause: let the pipeline drain fully.
      while (pending != 0) @(posedge clock);

      for (k = 0; k < 380; k++) begin
         t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         if ($urandom_range(0, 7) == 0) t.b_x = -t.a_x;
         offer(t, k < 300);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("sphere_edge_midpoint_normalizer_top: match");
      else
         $display("sphere_edge_midpoint_normalizer_top: mismatch");
      $finish;
   end

   // Run guard, far beyond the slowest legitimate run.
   initial begin
      #2000000;
      $display("sphere_edge_midpoint_normalizer_top: mismatch");
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_div.sv
rtl/core/sem_lane.sv
rtl/core/sem_merge.sv
rtl/core/sphere_edge_midpoint_normalizer_top.sv
rtl/core/sem_checker.sv
test/sphere_edge_midpoint_normalizer_checker.sv
test/sphere_edge_midpoint_normalizer_top_tb.sv
